// ===== rtl/ftdt_pkg.sv =====
`timescale 1ns / 1ps
package ftdt_pkg;

   // Default for the largest number of significant digits printed.
   localparam int MAX_SIG_DIGITS_DEF = 23;

   localparam logic [4:0] DIGITS_RESET = 5'd3;
   localparam logic signed [7:0] NDIG_DEFAULT = 8'sd7;

   localparam logic [6:0] CHAR_NUL   = 7'h00;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_POINT = 7'h2E;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   localparam logic signed [9:0] EXP_MIN_NORM = -10'sd126;
   localparam logic signed [9:0] EXP_BIAS = 10'sd127;
   localparam logic [23:0] MANT_ONE = 24'h800000;
   localparam logic [23:0] MANT_TEN = 24'hA00000;

   // One classified input value: mantissa with hidden bit, unbiased exponent.
   typedef struct packed {
      logic                not_finite;
      logic                neg;
      logic [23:0]         mant;
      logic signed [9:0]   expo;
   } ftdt_item_type;

   // One character of output text.
   typedef struct packed {
      logic [6:0] code;
      logic       last;
      logic       not_finite;
   } ftdt_char_type;

endpackage

// ===== rtl/float_to_decimal_text.sv =====
`timescale 1ns / 1ps
// Converts IEEE single-precision values to fixed-point decimal text, one ASCII
// character per result transfer, the final character of each number flagged by
// last_char. Infinity and NaN give a single result with not_finite set. Items
// are taken one at a time by the conversion engine; a two-entry queue on each
// side lets the input accept ahead and the output hold finished characters.
// Per item, scaling runs multiply-by-ten steps (multiply, round, normalise) or
// divide-by-ten steps (five passes of the 8-bit-per-cycle divider plus rounding
// and normalising), then one such divide for each digit after the first builds the
// rounding term, and then the characters are emitted with a multiply after each digit.
module float_to_decimal_text #(
   parameter int MAX_SIG_DIGITS = ftdt_pkg::MAX_SIG_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_value_bits,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_last_char,
   output logic        rsp_not_finite,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_digits_after_point
);
   import ftdt_pkg::*;

   localparam int CharBits = $bits(ftdt_char_type);

   logic [4:0]          digits_ff;
   logic                item_valid;
   logic                item_pop;
   ftdt_item_type       item;
   logic                out_full;
   logic                out_push;
   ftdt_char_type       out_char;
   logic [CharBits-1:0] rsp_data;
   ftdt_char_type       rsp_char;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= DIGITS_RESET;
      end else if (csr_valid && csr_ready) begin
         digits_ff <= csr_digits_after_point;
      end
   end

   ftdt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_value_bits (req_value_bits),
      .req_full       (req_full),
      .item_pop       (item_pop),
      .item_valid     (item_valid),
      .item           (item)
   );

   ftdt_core #(.MAX_SIG_DIGITS(MAX_SIG_DIGITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .prec       (digits_ff),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_char   (out_char)
   );

   ftdt_queue #(.WIDTH(CharBits)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_char),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_char       = ftdt_char_type'(rsp_data);
   assign rsp_char_code  = rsp_char.code;
   assign rsp_last_char  = rsp_char.last;
   assign rsp_not_finite = rsp_char.not_finite;

endmodule

// ===== rtl/ftdt_queue.sv =====
`timescale 1ns / 1ps
module ftdt_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam logic [1:0] FULL_COUNT = 2'd2;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wptr_ff;
   logic             rptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

// ===== rtl/ftdt_front.sv =====
`timescale 1ns / 1ps
module ftdt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [31:0]            req_value_bits,
   output logic                   req_full,
   input  logic                   item_pop,
   output logic                   item_valid,
   output ftdt_pkg::ftdt_item_type item
);
   import ftdt_pkg::*;

   localparam int ItemBits = $bits(ftdt_item_type);

   logic [7:0]      exp_field;
   ftdt_item_type   cls;
   logic [ItemBits-1:0] q_data;
   logic            q_empty;

   assign exp_field = req_value_bits[30:23];

   // Unpack to hidden-bit mantissa and unbiased exponent; subnormals sit at the
   // minimum exponent with the hidden bit clear. Negative zero loses its sign.
   always_comb begin
      cls.not_finite = &exp_field;
      cls.neg        = req_value_bits[31] && (|req_value_bits[30:0]);
      cls.mant       = {(|exp_field), req_value_bits[22:0]};
      cls.expo       = (exp_field == 8'd0) ? EXP_MIN_NORM
                       : ($signed({2'b00, exp_field}) - EXP_BIAS);
   end

   ftdt_queue #(.WIDTH(ItemBits)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cls),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign item_valid = !q_empty;
   assign item       = ftdt_item_type'(q_data);

endmodule

// ===== rtl/ftdt_core.sv =====
`timescale 1ns / 1ps
module ftdt_core #(
   parameter int MAX_SIG_DIGITS = ftdt_pkg::MAX_SIG_DIGITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  ftdt_pkg::ftdt_item_type item,
   output logic                    item_pop,
   input  logic [4:0]              prec,
   input  logic                    out_full,
   output logic                    out_push,
   output ftdt_pkg::ftdt_char_type out_char
);
   import ftdt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_NORM, S_SCALE_UP, S_SCALE_DN, S_YLOOP, S_DIV, S_ROUND, S_HALF,
      S_ADD, S_CARRY, S_SIGN, S_LEAD, S_LPT, S_ZERO, S_DIG, S_DPT, S_DMUL
   } state_type;

   state_type         state_ff;
   state_type         ret_ff;
   logic [23:0]       xm_ff;
   logic signed [9:0] xe_ff;
   logic [23:0]       ym_ff;
   logic signed [9:0] ye_ff;
   logic              dst_ff;       // operation target: 1 selects y
   logic              neg_ff;
   logic signed [7:0] ie_ff;
   logic signed [7:0] ndig_ff;
   logic signed [7:0] cnt_ff;
   logic signed [7:0] zc_ff;
   logic              dpt_last_ff;
   logic [27:0]       opm_ff;
   logic              ops_ff;
   logic signed [9:0] ope_ff;
   logic [39:0]       divd_ff;
   logic [29:0]       divq_ff;
   logic [3:0]        rem_ff;
   logic [2:0]        dstep_ff;

   // Datapath results.
   logic signed [7:0] ndig_init;
   logic [27:0]       mul_p;
   logic [27:0]       mul_m;
   logic signed [9:0] mul_e;
   logic [7:0]        div_bits;
   logic [3:0]        div_rem;
   logic [4:0]        div_r5;
   logic [29:0]       div_q;
   logic [27:0]       div_m;
   logic              div_s;
   logic signed [9:0] div_e;
   logic signed [9:0] src_e;
   logic signed [9:0] rsh_full;
   logic              rnd_sub;
   logic [4:0]        rnd_shamt;
   logic [31:0]       rnd_sh;
   logic              rnd_lost;
   logic              rnd_up;
   logic [24:0]       rnd_sum;
   logic [23:0]       rnd_m;
   logic signed [9:0] rnd_e;
   logic [23:0]       nrm_src;
   logic signed [9:0] nrm_src_e;
   logic              nrm_done;
   logic [23:0]       nrm_m;
   logic signed [9:0] nrm_e;
   logic signed [9:0] add_d;
   logic              add_far;
   logic [26:0]       add_ya;
   logic [26:0]       add_yal;
   logic              add_st;
   logic [27:0]       add_sum;
   logic [27:0]       add_m;
   logic signed [9:0] add_e;
   logic              x_zero;
   logic              x_lt1;
   logic              x_ge10;
   logic              x_ge1;
   logic [4:0]        dig_sh;
   logic [3:0]        dig_k;
   logic [23:0]       dig_frac;
   logic signed [7:0] ie_pt;
   logic              emit_valid;
   ftdt_char_type     emit_char;

   assign ndig_init = (prec == 5'd0) ? NDIG_DEFAULT
                      : ((int'(prec) > MAX_SIG_DIGITS - 1) ? 8'(MAX_SIG_DIGITS)
                      : $signed({3'b000, prec} + 8'd1));

   // Multiply x by ten exactly, then line the product up for rounding.
   assign mul_p = {1'b0, xm_ff, 3'b000} + {3'b000, xm_ff, 1'b0};
   assign mul_m = mul_p[27] ? mul_p : {mul_p[26:0], 1'b0};
   assign mul_e = xe_ff + (mul_p[27] ? 10'sd4 : 10'sd3);

   // Divide by ten: eight restoring steps per cycle on a four-bit remainder.
   always_comb begin
      div_rem = rem_ff;
      div_r5  = '0;
      for (int j = 0; j < 8; j++) begin
         div_r5 = {div_rem, divd_ff[39-j]};
         if (div_r5 >= 5'd10) begin
            div_bits[7-j] = 1'b1;
            div_r5 = div_r5 - 5'd10;
         end else begin
            div_bits[7-j] = 1'b0;
         end
         div_rem = div_r5[3:0];
      end
   end

   assign src_e = dst_ff ? ye_ff : xe_ff;
   assign div_q = {divq_ff[21:0], div_bits};
   always_comb begin
      if (div_q[29]) begin
         div_m = div_q[29:2];
         div_s = (|div_q[1:0]) || (div_rem != 4'd0);
         div_e = src_e - 10'sd3;
      end else begin
         div_m = div_q[28:1];
         div_s = div_q[0] || (div_rem != 4'd0);
         div_e = src_e - 10'sd4;
      end
   end

   // Round to nearest even; below the normal range the grid is coarser.
   assign rsh_full  = EXP_MIN_NORM - ope_ff;
   assign rnd_sub   = (ope_ff < EXP_MIN_NORM);
   assign rnd_shamt = !rnd_sub ? 5'd0 : ((rsh_full > 10'sd31) ? 5'd31 : rsh_full[4:0]);
   assign rnd_sh    = {4'b0000, opm_ff} >> rnd_shamt;
   assign rnd_lost  = |({4'b0000, opm_ff} & ((32'd1 << rnd_shamt) - 32'd1));
   assign rnd_up    = rnd_sh[3] && ((|rnd_sh[2:0]) || ops_ff || rnd_lost || rnd_sh[4]);
   assign rnd_sum   = {1'b0, rnd_sh[27:4]} + {24'd0, rnd_up};
   assign rnd_m     = rnd_sum[24] ? rnd_sum[24:1] : rnd_sum[23:0];
   assign rnd_e     = (rnd_sub ? EXP_MIN_NORM : ope_ff) + (rnd_sum[24] ? 10'sd1 : 10'sd0);

   assign nrm_src   = dst_ff ? ym_ff : xm_ff;
   assign nrm_src_e = dst_ff ? ye_ff : xe_ff;
   assign nrm_done  = (nrm_src == 24'd0) || nrm_src[23];
   always_comb begin
      if (nrm_src[23:16] == 8'd0) begin
         nrm_m = {nrm_src[15:0], 8'd0};
         nrm_e = nrm_src_e - 10'sd8;
      end else if (nrm_src[23:20] == 4'd0) begin
         nrm_m = {nrm_src[19:0], 4'd0};
         nrm_e = nrm_src_e - 10'sd4;
      end else begin
         nrm_m = {nrm_src[22:0], 1'b0};
         nrm_e = nrm_src_e - 10'sd1;
      end
   end

   // x + y with three guard bits; y is always the smaller operand here.
   assign add_d   = xe_ff - ye_ff;
   assign add_far = (add_d > 10'sd26);
   assign add_ya  = {ym_ff, 3'b000};
   assign add_yal = add_far ? 27'd0 : (add_ya >> add_d[4:0]);
   assign add_st  = add_far ? (ym_ff != 24'd0)
                    : (|(add_ya & ((27'd1 << add_d[4:0]) - 27'd1)));
   assign add_sum = {1'b0, xm_ff, 3'b000} + {1'b0, add_yal[26:1], add_yal[0] | add_st};
   assign add_m   = add_sum[27] ? add_sum : {add_sum[26:0], 1'b0};
   assign add_e   = xe_ff + (add_sum[27] ? 10'sd1 : 10'sd0);

   assign x_zero = (xm_ff == 24'd0);
   assign x_lt1  = !x_zero && (xe_ff < 10'sd0);
   assign x_ge1  = !x_zero && (xe_ff >= 10'sd0);
   assign x_ge10 = !x_zero && ((xe_ff > 10'sd3) || ((xe_ff == 10'sd3) && (xm_ff >= MANT_TEN)));

   assign dig_sh   = 5'd23 - xe_ff[4:0];
   assign dig_k    = x_ge1 ? 4'(xm_ff >> dig_sh) : 4'd0;
   assign dig_frac = x_ge1 ? (xm_ff & ((24'd1 << dig_sh) - 24'd1)) : xm_ff;

   assign ie_pt = (ndig_ff < 8'sd0) ? (ie_ff - ndig_ff) : ie_ff;

   always_comb begin
      emit_valid = 1'b0;
      emit_char  = '{code: CHAR_NUL, last: 1'b0, not_finite: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (item_valid && item.not_finite) begin
               emit_valid = 1'b1;
               emit_char  = '{code: CHAR_NUL, last: 1'b1, not_finite: 1'b1};
            end
         end
         S_SIGN: begin
            emit_valid     = neg_ff;
            emit_char.code = CHAR_MINUS;
         end
         S_LEAD: begin
            emit_valid     = (ie_ff < 8'sd0);
            emit_char.code = CHAR_ZERO;
         end
         S_LPT: begin
            emit_valid     = 1'b1;
            emit_char.code = CHAR_POINT;
            emit_char.last = (zc_ff <= 8'sd0) && (ndig_ff <= 8'sd0);
         end
         S_ZERO: begin
            emit_valid     = (zc_ff > 8'sd0);
            emit_char.code = CHAR_ZERO;
            emit_char.last = (zc_ff == 8'sd1) && (ndig_ff <= 8'sd0);
         end
         S_DIG: begin
            emit_valid     = (cnt_ff < ndig_ff);
            emit_char.code = CHAR_ZERO + {3'b000, dig_k};
            emit_char.last = (cnt_ff == ndig_ff - 8'sd1) && (cnt_ff != ie_ff);
         end
         S_DPT: begin
            emit_valid     = 1'b1;
            emit_char.code = CHAR_POINT;
            emit_char.last = dpt_last_ff;
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   assign out_push = emit_valid && !out_full;
   assign out_char = emit_char;
   assign item_pop = (state_ff == S_IDLE) && item_valid && (!item.not_finite || !out_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (item_pop && !item.not_finite) begin
                  xm_ff    <= item.mant;
                  xe_ff    <= item.expo;
                  neg_ff   <= item.neg;
                  ie_ff    <= 8'sd0;
                  ndig_ff  <= ndig_init;
                  dst_ff   <= 1'b0;
                  ret_ff   <= S_SCALE_UP;
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (nrm_done) begin
                  state_ff <= ret_ff;
               end else if (dst_ff) begin
                  ym_ff <= nrm_m;
                  ye_ff <= nrm_e;
               end else begin
                  xm_ff <= nrm_m;
                  xe_ff <= nrm_e;
               end
            end
            S_SCALE_UP: begin
               if (x_lt1) begin
                  opm_ff   <= mul_m;
                  ops_ff   <= 1'b0;
                  ope_ff   <= mul_e;
                  dst_ff   <= 1'b0;
                  ie_ff    <= ie_ff - 8'sd1;
                  ret_ff   <= S_SCALE_UP;
                  state_ff <= S_ROUND;
               end else begin
                  state_ff <= S_SCALE_DN;
               end
            end
            S_SCALE_DN: begin
               if (x_ge10) begin
                  divd_ff  <= {7'd0, xm_ff, 9'd0};
                  divq_ff  <= '0;
                  rem_ff   <= '0;
                  dstep_ff <= '0;
                  dst_ff   <= 1'b0;
                  ie_ff    <= ie_ff + 8'sd1;
                  ret_ff   <= S_SCALE_DN;
                  state_ff <= S_DIV;
               end else begin
                  ndig_ff  <= ndig_ff + ie_ff;
                  ym_ff    <= MANT_ONE;
                  ye_ff    <= 10'sd0;
                  cnt_ff   <= 8'sd1;
                  state_ff <= S_YLOOP;
               end
            end
            S_YLOOP: begin
               if (cnt_ff < ndig_ff) begin
                  cnt_ff <= cnt_ff + 8'sd1;
                  if (ym_ff != 24'd0) begin
                     divd_ff  <= {7'd0, ym_ff, 9'd0};
                     divq_ff  <= '0;
                     rem_ff   <= '0;
                     dstep_ff <= '0;
                     dst_ff   <= 1'b1;
                     ret_ff   <= S_YLOOP;
                     state_ff <= S_DIV;
                  end
               end else begin
                  state_ff <= S_HALF;
               end
            end
            S_DIV: begin
               divd_ff  <= {divd_ff[31:0], 8'd0};
               divq_ff  <= div_q;
               rem_ff   <= div_rem;
               dstep_ff <= dstep_ff + 3'd1;
               if (dstep_ff == 3'd4) begin
                  opm_ff   <= div_m;
                  ops_ff   <= div_s;
                  ope_ff   <= div_e;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               if (dst_ff) begin
                  ym_ff <= rnd_m;
                  ye_ff <= rnd_e;
               end else begin
                  xm_ff <= rnd_m;
                  xe_ff <= rnd_e;
               end
               state_ff <= S_NORM;
            end
            S_HALF: begin
               if (ym_ff != 24'd0) begin
                  opm_ff   <= {ym_ff, 4'd0};
                  ops_ff   <= 1'b0;
                  ope_ff   <= ye_ff - 10'sd1;
                  dst_ff   <= 1'b1;
                  ret_ff   <= S_ADD;
                  state_ff <= S_ROUND;
               end else begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               if (x_zero) begin
                  opm_ff <= {ym_ff, 4'd0};
                  ope_ff <= ye_ff;
               end else if (ym_ff == 24'd0) begin
                  opm_ff <= {xm_ff, 4'd0};
                  ope_ff <= xe_ff;
               end else begin
                  opm_ff <= add_m;
                  ope_ff <= add_e;
               end
               ops_ff   <= 1'b0;
               dst_ff   <= 1'b0;
               ret_ff   <= S_CARRY;
               state_ff <= S_ROUND;
            end
            S_CARRY: begin
               // A carry to ten restarts from exactly one; the digit count stays.
               if (x_ge10) begin
                  xm_ff <= MANT_ONE;
                  xe_ff <= 10'sd0;
                  ie_ff <= ie_ff + 8'sd1;
               end
               cnt_ff   <= 8'sd0;
               state_ff <= S_SIGN;
            end
            S_SIGN: begin
               if (!neg_ff || !out_full) begin
                  state_ff <= S_LEAD;
               end
            end
            S_LEAD: begin
               if (ie_ff >= 8'sd0) begin
                  state_ff <= S_DIG;
               end else if (!out_full) begin
                  zc_ff    <= -8'sd1 - ie_pt;
                  state_ff <= S_LPT;
               end
            end
            S_LPT: begin
               if (!out_full) begin
                  state_ff <= S_ZERO;
               end
            end
            S_ZERO: begin
               if (zc_ff <= 8'sd0) begin
                  state_ff <= S_DIG;
               end else if (!out_full) begin
                  zc_ff <= zc_ff - 8'sd1;
               end
            end
            S_DIG: begin
               if (cnt_ff >= ndig_ff) begin
                  state_ff <= S_IDLE;
               end else if (!out_full) begin
                  xm_ff  <= dig_frac;
                  dst_ff <= 1'b0;
                  ret_ff <= S_DMUL;
                  if (cnt_ff == ie_ff) begin
                     dpt_last_ff <= (cnt_ff == ndig_ff - 8'sd1);
                     state_ff    <= S_DPT;
                  end else begin
                     state_ff <= S_NORM;
                  end
               end
            end
            S_DPT: begin
               if (!out_full) begin
                  state_ff <= S_NORM;
               end
            end
            S_DMUL: begin
               cnt_ff <= cnt_ff + 8'sd1;
               if (!x_zero) begin
                  opm_ff   <= mul_m;
                  ops_ff   <= 1'b0;
                  ope_ff   <= mul_e;
                  ret_ff   <= S_DIG;
                  state_ff <= S_ROUND;
               end else begin
                  state_ff <= S_DIG;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("character transfer issued into a full queue");

   a_scale_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCALE_DN && !x_zero) |-> xm_ff[23])
      else $error("x not normalised during scaling");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIG && !x_zero) |-> (xm_ff[23] && xe_ff <= 10'sd3))
      else $error("digit source outside [0,16)");
`endif

endmodule
